// ===== rtl/ctr_pkg.sv =====
// shared constants, types and register codes for the compact target retarget unit
`timescale 1ns / 1ps

package ctr_pkg;

    // field widths
    localparam int WORD_W     = 32;
    localparam int TS_W       = 28;
    localparam int SPAN_W     = 30;
    localparam int MANT_W     = 23;
    localparam int PROD_W     = MANT_W + SPAN_W;
    localparam int VAL_W      = 256;
    localparam int VAL_BYTES  = VAL_W / 8;
    localparam int SIZE_W     = 6;
    localparam int SHIFT_W    = 8;

    // long division: quotient bits per pipeline stage
    localparam int DIV_BITS   = 4;
    localparam int DIV_STAGES = VAL_W / DIV_BITS;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_TIMESPAN    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NO_RETARGET = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_SHIFT = 8'd2;

    localparam logic [TS_W-1:0]    TIMESPAN_RST    = 28'd1209600;
    localparam logic [SHIFT_W-1:0] LIMIT_SHIFT_RST = 8'd32;

    typedef struct packed {
        logic [TS_W-1:0]    timespan;
        logic               no_retarget;
        logic [SHIFT_W-1:0] limit_shift;
    } cfg_t;

    // per item data that rides alongside the arithmetic
    typedef struct packed {
        logic              bypass;
        logic [WORD_W-1:0] prev;
    } side_t;

    // bus between pipeline sections
    typedef struct packed {
        logic             valid;
        side_t            side;
        logic [VAL_W-1:0] val;
    } val_bus_t;

    // final section result
    typedef struct packed {
        logic              valid;
        logic              bypass;
        logic [WORD_W-1:0] compact;
    } res_bus_t;

endpackage

// ===== rtl/ctr_in_if.sv =====
// input item channel
`timescale 1ns / 1ps

interface ctr_in_if import ctr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] prev_compact;
    logic [WORD_W-1:0] last_time;
    logic [WORD_W-1:0] first_time;

    modport source (output valid, output prev_compact, output last_time,
                    output first_time, input ready);
    modport sink   (input valid, input prev_compact, input last_time,
                    input first_time, output ready);
endinterface

// ===== rtl/ctr_out_if.sv =====
// result item channel
`timescale 1ns / 1ps

interface ctr_out_if import ctr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] next_compact;

    modport source (output valid, output next_compact, input ready);
    modport sink   (input valid, input next_compact, output ready);
endinterface

// ===== rtl/ctr_cfg_if.sv =====
// configuration write channel
`timescale 1ns / 1ps

interface ctr_cfg_if import ctr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ctr_front.sv =====
// front section: clamp elapsed time, scale mantissa, expand to a 256-bit dividend
`timescale 1ns / 1ps

module ctr_front import ctr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  cfg_t              cfg,
    input  logic              in_valid,
    input  logic [WORD_W-1:0] prev_compact,
    input  logic [WORD_W-1:0] last_time,
    input  logic [WORD_W-1:0] first_time,
    output val_bus_t          bus
);

    // stage 1 signals
    logic [WORD_W:0]      span_raw;
    logic [WORD_W-1:0]    lo_bound;
    logic [WORD_W-1:0]    hi_bound;
    logic [SPAN_W-1:0]    span_next;
    logic [7:0]           size;
    logic [MANT_W-1:0]    mant;
    logic [MANT_W-1:0]    mant_next;
    logic [7:0]           kbytes_next;

    logic                 v1_reg, v2_reg, v3_reg;
    side_t                side1_reg, side2_reg, side3_reg;
    logic [SPAN_W-1:0]    span1_reg;
    logic [MANT_W-1:0]    mant1_reg;
    logic [7:0]           kbytes1_reg, kbytes2_reg;
    logic [PROD_W-1:0]    prod2_reg;
    logic [VAL_W-1:0]     val3_reg;
    logic [VAL_W-1:0]     wide;
    logic [VAL_W-1:0]     val_next;

    // clamp of the signed elapsed time
    always_comb
    begin
        span_raw = {1'b0, last_time} - {1'b0, first_time};
        lo_bound = WORD_W'(cfg.timespan >> 2);
        hi_bound = WORD_W'({cfg.timespan, 2'b00});
        if (span_raw[WORD_W] || (span_raw[WORD_W-1:0] < lo_bound))
        begin
            span_next = SPAN_W'(lo_bound);
        end
        else if (span_raw[WORD_W-1:0] > hi_bound)
        begin
            span_next = SPAN_W'(hi_bound);
        end
        else
        begin
            span_next = SPAN_W'(span_raw[WORD_W-1:0]);
        end
    end

    // mantissa alignment for small exponents, byte shift for large ones
    always_comb
    begin
        size = prev_compact[31:24];
        mant = prev_compact[MANT_W-1:0];
        unique case (size)
            8'd0:
            begin
                mant_next   = '0;
                kbytes_next = '0;
            end
            8'd1:
            begin
                mant_next   = mant >> 16;
                kbytes_next = '0;
            end
            8'd2:
            begin
                mant_next   = mant >> 8;
                kbytes_next = '0;
            end
            8'd3:
            begin
                mant_next   = mant;
                kbytes_next = '0;
            end
            default:
            begin
                mant_next   = mant;
                kbytes_next = size - 8'd3;
            end
        endcase
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // dividend placement
    always_comb
    begin
        wide = VAL_W'(prod2_reg);
        if (kbytes2_reg >= 8'(VAL_BYTES))
        begin
            val_next = '0;
        end
        else
        begin
            val_next = wide << {kbytes2_reg[4:0], 3'b000};
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side1_reg   <= '{bypass: cfg.no_retarget, prev: prev_compact};
            span1_reg   <= span_next;
            mant1_reg   <= mant_next;
            kbytes1_reg <= kbytes_next;

            side2_reg   <= side1_reg;
            prod2_reg   <= PROD_W'(mant1_reg) * PROD_W'(span1_reg);
            kbytes2_reg <= kbytes1_reg;

            side3_reg   <= side2_reg;
            val3_reg    <= val_next;
        end
    end

    assign bus = '{valid: v3_reg, side: side3_reg, val: val3_reg};

endmodule

// ===== rtl/ctr_div.sv =====
// pipelined restoring divider by the target timespan, four quotient bits per stage
`timescale 1ns / 1ps

module ctr_div import ctr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [TS_W-1:0]  divisor,
    input  val_bus_t         din,
    output val_bus_t         dout
);

    typedef struct packed {
        logic [TS_W-1:0]  rem;
        logic [VAL_W-1:0] work;
    } div_state_t;

    // DIV_BITS shift-subtract steps; quotient bits shift in from the right
    function automatic div_state_t div_step(div_state_t s, logic [TS_W-1:0] d);
        div_state_t    r;
        logic [TS_W:0] trial;
        r = s;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial = {r.rem, r.work[VAL_W-1]};
            if (trial >= {1'b0, d})
            begin
                trial  = trial - {1'b0, d};
                r.work = {r.work[VAL_W-2:0], 1'b1};
            end
            else
            begin
                r.work = {r.work[VAL_W-2:0], 1'b0};
            end
            r.rem = trial[TS_W-1:0];
        end
        return r;
    endfunction

    div_state_t             st_reg   [DIV_STAGES];
    side_t                  side_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0]  vld_reg;

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_stage
        div_state_t st_in;
        side_t      side_in;
        logic       vld_in;

        if (g == 0)
        begin : g_first
            assign st_in   = '{rem: '0, work: din.val};
            assign side_in = din.side;
            assign vld_in  = din.valid;
        end
        else
        begin : g_rest
            assign st_in   = st_reg[g-1];
            assign side_in = side_reg[g-1];
            assign vld_in  = vld_reg[g-1];
        end

        // valid bit of this stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else if (advance)
            begin
                vld_reg[g] <= vld_in;
            end
        end

        // remainder and partial quotient
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                st_reg[g]   <= div_step(st_in, divisor);
                side_reg[g] <= side_in;
            end
        end
    end

    assign dout = '{valid: vld_reg[DIV_STAGES-1], side: side_reg[DIV_STAGES-1],
                    val: st_reg[DIV_STAGES-1].work};

endmodule

// ===== rtl/ctr_pack.sv =====
// back section: cap at the limit, find the byte size, pack to compact form
`timescale 1ns / 1ps

module ctr_pack import ctr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  cfg_t      cfg,
    input  val_bus_t  din,
    output res_bus_t  dout
);

    logic [VAL_W-1:0]  lim;
    logic [VAL_W-1:0]  q_eff;
    logic [VAL_W-1:0]  capped;
    logic [SIZE_W-1:0] size_next;
    logic [4:0]        lo_shift;
    logic [SIZE_W-1:0] hi_bytes;
    logic [23:0]       mant_c;
    logic [SIZE_W-1:0] size_c;
    logic [WORD_W-1:0] compact_next;

    logic              v1_reg, v2_reg, v3_reg;
    side_t             side1_reg, side2_reg;
    logic              bypass3_reg;
    logic [VAL_W-1:0]  q1_reg, q2_reg;
    logic [SIZE_W-1:0] size2_reg;
    logic [WORD_W-1:0] compact3_reg;

    // zero divisor gives all ones, then the cap
    always_comb
    begin
        lim    = {VAL_W{1'b1}} >> cfg.limit_shift;
        q_eff  = (cfg.timespan == '0) ? {VAL_W{1'b1}} : din.val;
        capped = (q_eff > lim) ? lim : q_eff;
    end

    // byte count up to the highest nonzero byte
    always_comb
    begin
        size_next = '0;
        for (int i = 0; i < VAL_BYTES; i++)
        begin
            if (q1_reg[8*i +: 8] != 8'd0)
            begin
                size_next = SIZE_W'(i + 1);
            end
        end
    end

    // mantissa window, sign bit fix-up and bypass select
    always_comb
    begin
        lo_shift = {2'(2'd3 - size2_reg[1:0]), 3'b000};
        hi_bytes = size2_reg - SIZE_W'(3);
        if (size2_reg <= SIZE_W'(3))
        begin
            mant_c = 24'(q2_reg[23:0] << lo_shift);
        end
        else
        begin
            mant_c = 24'(q2_reg >> {hi_bytes[4:0], 3'b000});
        end
        size_c = size2_reg;
        if (mant_c[23])
        begin
            mant_c = mant_c >> 8;
            size_c = size2_reg + SIZE_W'(1);
        end
        if (side2_reg.bypass)
        begin
            compact_next = side2_reg.prev;
        end
        else
        begin
            compact_next = {8'(size_c), mant_c};
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= din.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side1_reg    <= din.side;
            q1_reg       <= capped;
            side2_reg    <= side1_reg;
            q2_reg       <= q1_reg;
            size2_reg    <= size_next;
            bypass3_reg  <= side2_reg.bypass;
            compact3_reg <= compact_next;
        end
    end

    assign dout = '{valid: v3_reg, bypass: bypass3_reg, compact: compact3_reg};

endmodule

// ===== rtl/compact_target_retarget_unit.sv =====
// top level of the compact target retarget unit
//
// Channels: item takes prev_compact, last_time and first_time; result returns
// next_compact; cfg writes target_timespan (index 0), no_retarget (index 1)
// and limit_shift (index 2), other indexes are dropped. cfg is always ready.
// Every item moves through a 70 stage pipeline: 3 front stages (clamp,
// 23 x 30 multiply, byte shift to 256 bits), 64 divider stages that each
// resolve 4 quotient bits, and 3 back stages (cap, byte size, pack).
// One item is taken in every cycle while the receiver keeps up, so
// throughput is 1 per cycle. No-retarget items ride the same pipeline, so
// order is always kept. When the receiver stalls with a result waiting, the
// whole pipeline holds and item.ready drops; nothing is lost or repeated.
// Reset clears all valid bits and loads the register reset values.
// Configuration is meant to be written only while no item is in flight.
`timescale 1ns / 1ps

module compact_target_retarget_unit import ctr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    ctr_in_if.sink    item,
    ctr_out_if.source result,
    ctr_cfg_if.sink   cfg
);

    cfg_t      cfg_reg;
    logic      advance;
    val_bus_t  front_bus;
    val_bus_t  div_bus;
    res_bus_t  res_bus;

    // global pipeline enable
    assign advance    = !res_bus.valid || result.ready;
    assign item.ready = advance;
    assign cfg.ready  = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timespan    <= TIMESPAN_RST;
            cfg_reg.no_retarget <= 1'b0;
            cfg_reg.limit_shift <= LIMIT_SHIFT_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_TIMESPAN:    cfg_reg.timespan    <= cfg.data[TS_W-1:0];
                REG_NO_RETARGET: cfg_reg.no_retarget <= cfg.data[0];
                REG_LIMIT_SHIFT: cfg_reg.limit_shift <= cfg.data[SHIFT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    ctr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .cfg          (cfg_reg),
        .in_valid     (item.valid),
        .prev_compact (item.prev_compact),
        .last_time    (item.last_time),
        .first_time   (item.first_time),
        .bus          (front_bus)
    );

    ctr_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .divisor (cfg_reg.timespan),
        .din     (front_bus),
        .dout    (div_bus)
    );

    ctr_pack u_pack (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cfg     (cfg_reg),
        .din     (div_bus),
        .dout    (res_bus)
    );

    assign result.valid        = res_bus.valid;
    assign result.next_compact = res_bus.compact;

    // input is refused only while a result is held up
    a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> (result.valid && !result.ready))
        else $error("item refused without output backpressure");

    // retargeted words never carry the sign bit
    a_no_sign_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !res_bus.bypass) |-> !result.next_compact[23])
        else $error("sign bit set in retargeted word");

    // a nonzero mantissa in a retargeted word always has a nonzero size
    a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !res_bus.bypass && (result.next_compact[22:0] != 23'd0))
        |-> (result.next_compact[31:24] != 8'd0))
        else $error("nonzero mantissa with zero size");

endmodule

// ===== dv/ctr_retarget_checker.sv =====
// checker for the compact target retarget unit: predicts and compares next_compact
`timescale 1ns / 1ps

module ctr_retarget_checker import ctr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ctr_in_if    item,
    ctr_out_if   result,
    ctr_cfg_if   cfg,
    output int   fail_count,
    output int   pending
);

    logic [TS_W-1:0]    cur_timespan;
    logic               cur_no_retarget;
    logic [SHIFT_W-1:0] cur_limit_shift;
    logic [WORD_W-1:0]  compact_q[$];

    // retarget one compact word under the current register values
    function automatic logic [WORD_W-1:0] retarget(input logic [WORD_W-1:0] prev,
                                                   input logic [WORD_W-1:0] last_t,
                                                   input logic [WORD_W-1:0] first_t);
        longint            span;
        longint            lo;
        longint            hi;
        int unsigned       size;
        int unsigned       nbits;
        logic [VAL_W-1:0]  val;
        logic [VAL_W-1:0]  lim;
        logic [VAL_W-1:0]  tmp;
        logic [23:0]       mant;
        if (cur_no_retarget)
            return prev;
        // clamp the signed elapsed time
        span = longint'({32'd0, last_t}) - longint'({32'd0, first_t});
        lo   = longint'(cur_timespan) / 4;
        hi   = longint'(cur_timespan) * 4;
        if (span < lo)
            span = lo;
        if (span > hi)
            span = hi;
        // expand, sign bit dropped
        size = prev[31:24];
        if (size <= 3)
            val = VAL_W'(prev[22:0]) >> (8 * (3 - size));
        else if (8 * (size - 3) >= VAL_W)
            val = '0;
        else
            val = VAL_W'(prev[22:0]) << (8 * (size - 3));
        // scale, wrap modulo 2^256
        val = val * VAL_W'(span);
        if (cur_timespan == 0)
            val = '1;
        else
            val = val / VAL_W'(cur_timespan);
        // cap at the easiest target
        lim = {VAL_W{1'b1}} >> cur_limit_shift;
        if (val > lim)
            val = lim;
        // pack
        nbits = 0;
        for (int b = VAL_W - 1; b >= 0; b--)
        begin
            if (val[b] && nbits == 0)
                nbits = b + 1;
        end
        size = (nbits + 7) / 8;
        if (size <= 3)
        begin
            tmp  = val << (8 * (3 - size));
            mant = tmp[23:0];
        end
        else
        begin
            tmp  = val >> (8 * (size - 3));
            mant = tmp[23:0];
        end
        if (mant[23])
        begin
            mant = mant >> 8;
            size++;
        end
        return {8'(size), mant};
    endfunction

    // watch the three channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_timespan    <= TIMESPAN_RST;
            cur_no_retarget <= 1'b0;
            cur_limit_shift <= LIMIT_SHIFT_RST;
            fail_count      <= 0;
            pending         <= 0;
            compact_q.delete();
        end
        else
        begin
            if (item.valid && item.ready)
                compact_q.push_back(retarget(item.prev_compact, item.last_time,
                                             item.first_time));
            if (result.valid && result.ready)
            begin
                if (compact_q.size() == 0)
                begin
                    $display("%0t unexpected next_compact: expected none, actual %h",
                             $time, result.next_compact);
                    fail_count <= fail_count + 1;
                end
                else if (compact_q[0] !== result.next_compact)
                begin
                    $display("%0t next_compact mismatch: expected %h, actual %h",
                             $time, compact_q[0], result.next_compact);
                    fail_count <= fail_count + 1;
                    void'(compact_q.pop_front());
                end
                else
                    void'(compact_q.pop_front());
            end
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_TIMESPAN)
                    cur_timespan <= cfg.data[TS_W-1:0];
                else if (cfg.index == REG_NO_RETARGET)
                    cur_no_retarget <= cfg.data[0];
                else if (cfg.index == REG_LIMIT_SHIFT)
                    cur_limit_shift <= cfg.data[SHIFT_W-1:0];
            end
            pending <= compact_q.size();
        end
    end

endmodule

// ===== dv/tb_compact_target_retarget_unit.sv =====
// testbench top for the compact target retarget unit: stimulus and verdict
`timescale 1ns / 1ps

module tb_compact_target_retarget_unit;
    import ctr_pkg::*;

    localparam int DRAIN_CYCLES = 80;
    localparam int IDLE_LIMIT   = 20000;
    localparam int HOLD_CYCLES  = 300;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    bit   hold_req;
    bit   quiet;
    logic [TS_W-1:0] ts_now;

    ctr_in_if  item ();
    ctr_out_if result ();
    ctr_cfg_if cfg ();

    compact_target_retarget_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg)
    );

    ctr_retarget_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .result     (result),
        .cfg        (cfg),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item.valid && item.ready) || (result.valid && result.ready) ||
                (cfg.valid && cfg.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // result receiver: random stall bursts and one long hold-off on request
    initial
    begin
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                result.ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                result.ready <= 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(posedge clk);
                @(posedge clk);
                result.ready <= 1'b1;
            end
            else
                result.ready <= 1'b1;
        end
    end

    // offer one item, with an occasional idle burst in front
    task automatic send_item(input logic [WORD_W-1:0] prev, input logic [WORD_W-1:0] last_t,
                             input logic [WORD_W-1:0] first_t);
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            item.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        item.valid        <= 1'b1;
        item.prev_compact <= prev;
        item.last_time    <= last_t;
        item.first_time   <= first_t;
        do @(posedge clk); while (!item.ready);
    endtask

    // stop offering and wait until every result is back
    task automatic drain();
        item.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        @(posedge clk);
        if (idx == REG_TIMESPAN)
            ts_now = data[TS_W-1:0];
    endtask

    // mostly realistic exponents, some fully random words
    function automatic logic [WORD_W-1:0] rand_compact();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return {8'($urandom_range(0, 34)), 1'($urandom), 23'($urandom)};
    endfunction

    task automatic send_random(input int count);
        logic [WORD_W-1:0] first_t;
        logic [WORD_W-1:0] span;
        for (int n = 0; n < count; n++)
        begin
            first_t = $urandom;
            case ($urandom_range(0, 5))
                0:       span = $urandom;
                1:       span = -WORD_W'($urandom_range(0, 100000));
                2:       span = $urandom_range(0, ts_now / 4 + 1);
                3:       span = WORD_W'(ts_now) * 4 + $urandom_range(0, 1000);
                default: span = $urandom_range(ts_now / 4, ts_now * 4);
            endcase
            send_item(rand_compact(), first_t + span, first_t);
        end
    endtask

    // main sequence
    initial
    begin
        rst_n             = 1'b0;
        hold_req          = 1'b0;
        quiet             = 1'b0;
        idle_cycles       = 0;
        ts_now            = TIMESPAN_RST;
        item.valid        = 1'b0;
        item.prev_compact = '0;
        item.last_time    = '0;
        item.first_time   = '0;
        cfg.valid         = 1'b0;
        cfg.index         = '0;
        cfg.data          = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: exponent and mantissa extremes, sign bit, time extremes
        send_item(32'h1d00ffff, 32'd1209600, 32'd0);
        send_item(32'h1d00ffff, 32'd0, 32'd1);
        send_item(32'h1d00ffff, 32'hffffffff, 32'd0);
        send_item(32'h1d00ffff, 32'd0, 32'hffffffff);
        send_item(32'h1b0404cb, 32'd600000, 32'd600000);
        send_item(32'h00000000, 32'd5000000, 32'd0);
        send_item(32'h01123456, 32'd1209600, 32'd0);
        send_item(32'h02123456, 32'd1209600, 32'd0);
        send_item(32'h03123456, 32'd1209600, 32'd0);
        send_item(32'h04923456, 32'd1209600, 32'd0);
        send_item(32'h1d7fffff, 32'd4838400, 32'd0);
        send_item(32'h20ffffff, 32'd4838400, 32'd0);
        send_item(32'h21123456, 32'd302400, 32'd0);
        send_item(32'h23123456, 32'd1209600, 32'd0);
        send_item(32'hff7fffff, 32'd1209600, 32'd0);
        send_item(32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_item(32'h00800000, 32'd1209600, 32'd0);
        send_item(32'h1c800000, 32'd1209600, 32'd0);
        send_item(32'h1f000001, 32'd4838400, 32'd0);
        send_item(32'h10000000, 32'd1209600, 32'd0);

        // random under reset values, with a long receiver hold-off
        hold_req = 1'b1;
        send_random(150);
        drain();

        // shortest legal timespan, no cap
        write_reg(REG_TIMESPAN, 32'd4);
        write_reg(REG_LIMIT_SHIFT, 32'd0);
        send_random(100);
        drain();

        // longest timespan, tightest cap, upper data bits ignored
        write_reg(REG_TIMESPAN, 32'hffffffff);
        write_reg(REG_LIMIT_SHIFT, 32'hffffffff);
        send_random(100);
        drain();

        // pass-through mode; writes to unknown indexes dropped
        write_reg(REG_NO_RETARGET, 32'hffffffff);
        write_reg(CFG_IDX_W'(3), 32'h0);
        write_reg(CFG_IDX_W'(255), 32'h0);
        send_random(80);
        drain();

        // timespan of zero
        write_reg(REG_NO_RETARGET, 32'd0);
        write_reg(REG_TIMESPAN, 32'd0);
        write_reg(REG_LIMIT_SHIFT, 32'd8);
        send_random(40);
        drain();

        // timespans below the quarter floor
        write_reg(REG_TIMESPAN, 32'd1);
        send_random(30);
        drain();
        write_reg(REG_TIMESPAN, 32'd3);
        send_random(30);
        drain();

        // mid range settings
        write_reg(REG_TIMESPAN, 32'($urandom_range(4, 2000000)));
        write_reg(REG_LIMIT_SHIFT, 32'($urandom_range(1, 254)));
        send_random(120);
        drain();

        // back to reset values, no idling to the end
        write_reg(REG_TIMESPAN, 32'(TIMESPAN_RST));
        write_reg(REG_LIMIT_SHIFT, 32'(LIMIT_SHIFT_RST));
        quiet = 1'b1;
        send_random(150);
        drain();

        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
